// File: hdl/difficulty_retarget_assert.svh
// assertion macros for the difficulty retarget block
`ifndef DIFFICULTY_RETARGET_ASSERT_SVH
`define DIFFICULTY_RETARGET_ASSERT_SVH

// next-cycle implication, masked while reset is asserted
`define DR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("difficulty_retarget check failed");

// next-cycle implication checked through reset as well
`define DR_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("difficulty_retarget reset check failed");

`endif

// File: hdl/dr_pkg.sv
// shared constants and types for the difficulty retarget block
`default_nettype none
package dr_pkg;
  localparam int unsigned TARGET_BYTES_DEF = 32;
  localparam int unsigned TT_W             = 30;
  localparam int unsigned MANT_W           = 23;
  localparam int unsigned TS_W             = 32;
  localparam int unsigned CW_W             = 32;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam logic [TT_W-1:0] TT_RESET     = 30'd1209600;
  localparam logic [CW_W-1:0] MIN_RESET    = 32'h0000_0000;
  localparam logic [CW_W-1:0] MAX_RESET    = 32'hffff_ffff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_TIMESPAN = 2'd0,
    REG_MIN_BITS        = 2'd1,
    REG_MAX_BITS        = 2'd2
  } dr_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_PACK
  } dr_state_t;
endpackage
`default_nettype wire

// File: hdl/difficulty_retarget.sv
// top level of the difficulty retarget block
//
// channel | direction | handshake          | payload
// in      | input     | in_push / in_full   | in_old_compact, in_actual_timespan
// out     | output    | out_pop / out_empty | out_new_compact
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// the back end works on one item at a time, in the steps idle, multiply, load, divide, pack
// the bit-serial long division, one quotient bit per cycle, is the longest of these steps
// two-entry queues sit before and after the back end, so input and output stall apart
// reset is synchronous, active low; cfg_ready is always high
`default_nettype none
module difficulty_retarget #(
  parameter int unsigned TARGET_BYTES = dr_pkg::TARGET_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire logic [dr_pkg::CW_W-1:0]     in_old_compact,
  input  wire logic [dr_pkg::TS_W-1:0]     in_actual_timespan,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic [dr_pkg::CW_W-1:0]          out_new_compact,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [dr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dr_pkg::CW_W-1:0]     cfg_data
);
  import dr_pkg::*;

  localparam int unsigned EW = $clog2(TARGET_BYTES);
  localparam int unsigned QE = MANT_W + EW + TS_W;

  logic [TT_W-1:0]   tt_r;
  logic [CW_W-1:0]   min_r, max_r;
  logic [MANT_W-1:0] f_mant, q_mant;
  logic [EW-1:0]     f_bexp, q_bexp;
  logic [TS_W-1:0]   f_ts, q_ts;
  logic              q_empty, q_pop, o_full, o_push;
  logic [CW_W-1:0]   o_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tt_r  <= TT_RESET;
      min_r <= MIN_RESET;
      max_r <= MAX_RESET;
    end else if (cfg_valid) begin
      priority case (cfg_index)
        REG_TARGET_TIMESPAN: tt_r  <= cfg_data[TT_W-1:0];
        REG_MIN_BITS:        min_r <= cfg_data;
        REG_MAX_BITS:        max_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dr_front #(.TARGET_BYTES(TARGET_BYTES), .EW(EW)) u_front (
    .old_compact     (in_old_compact),
    .actual_timespan (in_actual_timespan),
    .tt              (tt_r),
    .mant            (f_mant),
    .bexp            (f_bexp),
    .ts              (f_ts)
  );

  dr_fifo #(.W(QE), .DEPTH(QUEUE_DEPTH)) u_midq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata ({f_mant, f_bexp, f_ts}),
    .full  (in_full),
    .pop   (q_pop),
    .rdata ({q_mant, q_bexp, q_ts}),
    .empty (q_empty)
  );

  dr_back #(.TARGET_BYTES(TARGET_BYTES), .EW(EW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .tt       (tt_r),
    .min_bits (min_r),
    .max_bits (max_r),
    .q_empty  (q_empty),
    .q_mant   (q_mant),
    .q_bexp   (q_bexp),
    .q_ts     (q_ts),
    .q_pop    (q_pop),
    .o_full   (o_full),
    .o_push   (o_push),
    .o_data   (o_data)
  );

  dr_fifo #(.W(CW_W), .DEPTH(QUEUE_DEPTH)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .wdata (o_data),
    .full  (o_full),
    .pop   (out_pop),
    .rdata (out_new_compact),
    .empty (out_empty)
  );
endmodule
`default_nettype wire

// File: hdl/dr_fifo.sv
// small first-in first-out queue
`default_nettype none
module dr_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH-1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH-1)) ? '0 : rptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end
endmodule
`default_nettype wire

// File: hdl/dr_front.sv
// front end: timespan clamp and compact word expansion
`default_nettype none
module dr_front #(
  parameter int unsigned TARGET_BYTES = dr_pkg::TARGET_BYTES_DEF,
  parameter int unsigned EW           = $clog2(TARGET_BYTES)
) (
  input  wire logic [dr_pkg::CW_W-1:0]  old_compact,
  input  wire logic [dr_pkg::TS_W-1:0]  actual_timespan,
  input  wire logic [dr_pkg::TT_W-1:0]  tt,
  output logic [dr_pkg::MANT_W-1:0]     mant,
  output logic [EW-1:0]                 bexp,
  output logic [dr_pkg::TS_W-1:0]       ts
);
  import dr_pkg::*;

  logic [7:0]        size8;
  logic [MANT_W-1:0] word;
  logic              zero;
  logic [TS_W-1:0]   lo, hi;
  logic              neg, lt, gt;

  assign size8 = old_compact[31:24];
  assign word  = old_compact[MANT_W-1:0];
  assign zero  = (word == '0) || (size8 == 8'd0) || (size8 > 8'(TARGET_BYTES));

  always_comb begin
    mant = '0;
    bexp = '0;
    if (!zero) begin
      if (size8 <= 8'd3) begin
        mant = word >> {(2'd3 - size8[1:0]), 3'b000};
      end else begin
        mant = word;
        bexp = EW'(size8 - 8'd3);
      end
    end
  end

  assign lo  = {{(TS_W-TT_W+2){1'b0}}, tt[TT_W-1:2]};
  assign hi  = {tt, 2'b00};
  assign neg = actual_timespan[TS_W-1];
  assign lt  = neg || (actual_timespan < lo);
  assign gt  = !neg && (actual_timespan > hi);
  assign ts  = lt ? lo : (gt ? hi : actual_timespan);
endmodule
`default_nettype wire

// File: hdl/dr_back.sv
// back end: multiply, serial long division, recompression and bound clamp
`default_nettype none
module dr_back #(
  parameter int unsigned TARGET_BYTES = dr_pkg::TARGET_BYTES_DEF,
  parameter int unsigned EW           = $clog2(TARGET_BYTES)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [dr_pkg::TT_W-1:0]  tt,
  input  wire logic [dr_pkg::CW_W-1:0]  min_bits,
  input  wire logic [dr_pkg::CW_W-1:0]  max_bits,
  input  wire logic                     q_empty,
  input  wire logic [dr_pkg::MANT_W-1:0] q_mant,
  input  wire logic [EW-1:0]            q_bexp,
  input  wire logic [dr_pkg::TS_W-1:0]  q_ts,
  output logic                          q_pop,
  input  wire logic                     o_full,
  output logic                          o_push,
  output logic [dr_pkg::CW_W-1:0]       o_data
);
  import dr_pkg::*;

  localparam int unsigned QW  = 8 * TARGET_BYTES;
  localparam int unsigned PW  = QW + 32;
  localparam int unsigned PRW = MANT_W + TS_W;
  localparam int unsigned CNW = $clog2(PW);
  localparam int unsigned SW  = $clog2(TARGET_BYTES + 1);

  dr_state_t         state_r, state_nxt;
  logic [MANT_W-1:0] mant_r;
  logic [EW-1:0]     bexp_r;
  logic [TS_W-1:0]   ts_r;
  logic [PRW-1:0]    prod_r;
  logic [PW-1:0]     dvd_r;
  logic [TT_W-1:0]   rem_r;
  logic [QW-1:0]     quo_r;
  logic [CNW-1:0]    cnt_r;
  logic              found_r;
  logic [SW-1:0]     size_r;

  logic [TT_W:0]     cur;
  logic              ge;
  logic [TT_W-1:0]   rem_nxt;
  logic [23:0]       mant_pk;
  logic [CW_W-1:0]   comp, c_lo;

  assign cur     = {rem_r, dvd_r[PW-1]};
  assign ge      = (tt != '0) && (cur >= {1'b0, tt});
  assign rem_nxt = ge ? TT_W'(cur - {1'b0, tt}) : cur[TT_W-1:0];

  always_comb begin
    if (size_r <= SW'(3)) begin
      mant_pk = quo_r[23:0] << {(2'd3 - size_r[1:0]), 3'b000};
    end else begin
      mant_pk = 24'(quo_r >> {(size_r - SW'(3)), 3'b000});
    end
    comp   = found_r ? {8'(size_r), mant_pk} : '0;
    c_lo   = (comp < min_bits) ? min_bits : comp;
    o_data = (c_lo > max_bits) ? max_bits : c_lo;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!q_empty) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == '0) state_nxt = ST_PACK;
      ST_PACK: if (!o_full) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop  = 1'b0;
    o_push = 1'b0;
    unique case (state_r)
      ST_IDLE: q_pop  = !q_empty;
      ST_PACK: o_push = !o_full;
      default: begin
        q_pop  = 1'b0;
        o_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        mant_r <= q_mant;
        bexp_r <= q_bexp;
        ts_r   <= q_ts;
      end
      ST_MUL: begin
        prod_r <= PRW'(mant_r) * PRW'(ts_r);
      end
      ST_LOAD: begin
        dvd_r   <= PW'(prod_r) << {bexp_r, 3'b000};
        rem_r   <= '0;
        cnt_r   <= CNW'(PW - 1);
        found_r <= 1'b0;
        size_r  <= '0;
      end
      ST_DIV: begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[QW-2:0], ge};
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r - CNW'(1);
        if (ge && !found_r && (cnt_r < CNW'(QW))) begin
          found_r <= 1'b1;
          size_r  <= SW'(cnt_r >> 3) + SW'(1);
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

// File: hdl/dr_checker.sv
// port-level checks for the difficulty retarget block
`default_nettype none
`include "difficulty_retarget_assert.svh"
module dr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [31:0] out_new_compact,
  input wire logic        cfg_ready
);
  `DR_ASSERT_ALWAYS(a_rst_out_empty, clk, !rst_n, out_empty)
  `DR_ASSERT_ALWAYS(a_rst_in_open, clk, !rst_n, !in_full && cfg_ready)
  `DR_ASSERT_NEXT(a_out_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_new_compact))
endmodule

bind difficulty_retarget dr_checker u_dr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_new_compact (out_new_compact),
  .cfg_ready       (cfg_ready)
);
`default_nettype wire

// File: bench/tb_difficulty_retarget.sv
// self-checking testbench for the difficulty retarget block
`default_nettype none
module tb_difficulty_retarget;
  import dr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic [CW_W-1:0] in_old_compact;
  logic [TS_W-1:0] in_actual_timespan;
  logic out_empty;
  logic out_pop;
  logic [CW_W-1:0] out_new_compact;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CW_W-1:0] cfg_data;

  logic [TT_W-1:0] period_reg;
  logic [CW_W-1:0] floor_reg;
  logic [CW_W-1:0] ceil_reg;

  logic [CW_W-1:0] expected_compact[$];
  int errors = 0;
  int unsigned cycles = 0;

  difficulty_retarget dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_old_compact(in_old_compact),
    .in_actual_timespan(in_actual_timespan),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_new_compact(out_new_compact),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("difficulty_retarget: mismatch");
      $finish;
    end
  end

  function automatic logic [CW_W-1:0] retarget(logic [CW_W-1:0] oc, logic [TS_W-1:0] raw);
    longint span;
    longint lo;
    longint hi;
    logic [7:0] sz;
    logic [22:0] mant;
    logic [255:0] tgt;
    logic [319:0] prod;
    logic [319:0] quo;
    int nb;
    int sh;
    logic [CW_W-1:0] c;
    span = longint'($signed(raw));
    lo = longint'(period_reg) / 4;
    hi = longint'(period_reg) * 4;
    if (span < lo) span = lo;
    if (span > hi) span = hi;
    sz = oc[31:24];
    mant = oc[22:0];
    tgt = '0;
    if (mant != 0 && sz != 0 && sz <= 32) begin
      if (sz <= 3) begin
        sh = 8 * (3 - int'(sz));
        tgt = 256'(mant >> sh);
      end else begin
        sh = 8 * (int'(sz) - 3);
        tgt = 256'(mant);
        tgt = tgt << sh;
      end
    end
    prod = {64'b0, tgt} * {287'b0, span[32:0]};
    quo = (period_reg != 0) ? prod / {290'b0, period_reg} : '0;
    quo[319:256] = '0;
    nb = 0;
    for (int i = 0; i < 32; i++)
      if (quo[8*i +: 8] != 0) nb = i + 1;
    if (nb == 0) c = '0;
    else if (nb <= 3) c = {8'(nb), 24'(quo[23:0] << (8 * (3 - nb)))};
    else c = {8'(nb), quo[8*(nb-3) +: 24]};
    if (c < floor_reg) c = floor_reg;
    if (c > ceil_reg) c = ceil_reg;
    return c;
  endfunction

  task automatic send_item(logic [CW_W-1:0] oc, logic [TS_W-1:0] ts);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_old_compact <= oc;
    in_actual_timespan <= ts;
    do @(posedge clk); while (in_full);
    expected_compact = {expected_compact, retarget(oc, ts)};
  endtask

  task automatic write_reg(dr_reg_t idx, logic [CW_W-1:0] val);
    in_push <= 1'b0;
    wait (expected_compact.size() == 0);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TARGET_TIMESPAN: period_reg = val[TT_W-1:0];
      REG_MIN_BITS: floor_reg = val;
      REG_MAX_BITS: ceil_reg = val;
      default: ;
    endcase
  endtask

  function automatic logic [CW_W-1:0] rand_compact();
    logic [CW_W-1:0] c;
    c = $urandom;
    case ($urandom_range(0, 9))
      0: c[31:24] = 8'($urandom_range(0, 255));
      1: c[22:0] = '0;
      2: c[31:24] = 8'($urandom_range(0, 3));
      default: c[31:24] = 8'($urandom_range(1, 32));
    endcase
    return c;
  endfunction

  function automatic logic [TS_W-1:0] rand_span();
    logic [31:0] q;
    logic [31:0] f;
    q = period_reg / 4;
    f = period_reg * 4;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return (period_reg > 2) ? $urandom_range(0, q + 2) : $urandom_range(0, 3);
      2: return f - $urandom_range(0, 2) + $urandom_range(0, 4);
      default: return $urandom_range(q, f);
    endcase
  endfunction

  task automatic test_directed();
    send_item(32'h1d00_ffff, 32'd1209600);
    send_item(32'h1d00_ffff, 32'd0);
    send_item(32'h1d00_ffff, 32'h8000_0000);
    send_item(32'h1d00_ffff, 32'h7fff_ffff);
    send_item(32'h1d00_0000, 32'd2000000);
    send_item(32'h0012_3456, 32'd2000000);
    send_item(32'h2112_3456, 32'd2000000);
    send_item(32'hff7f_ffff, 32'd2000000);
    send_item(32'h0112_3456, 32'd1209600);
    send_item(32'h0212_3456, 32'd1209600);
    send_item(32'h0312_3456, 32'd1209600);
    send_item(32'h2000_0001, 32'd4838400);
    send_item(32'h207f_ffff, 32'd4838400);
    send_item(32'h20ff_ffff, 32'd4000000);
    send_item(32'h0400_0001, 32'd302400);
    send_item(32'h0180_0001, 32'd4838400);
    send_item(32'h0300_0001, 32'd302400);
    send_item(32'h1b7f_ffff, 32'hffff_ffff);
  endtask

  task automatic test_period_extremes();
    write_reg(REG_TARGET_TIMESPAN, 32'd1);
    for (int i = 0; i < 20; i++) send_item(rand_compact(), rand_span());
    write_reg(REG_TARGET_TIMESPAN, 32'h3fff_ffff);
    for (int i = 0; i < 20; i++) send_item(rand_compact(), rand_span());
    write_reg(REG_TARGET_TIMESPAN, 32'hc000_0000);
    for (int i = 0; i < 10; i++) send_item(rand_compact(), $urandom);
    write_reg(REG_TARGET_TIMESPAN, 32'd1209600);
  endtask

  task automatic test_bounds();
    write_reg(REG_MIN_BITS, 32'h1c00_ffff);
    write_reg(REG_MAX_BITS, 32'h1e7f_ffff);
    for (int i = 0; i < 30; i++) send_item(rand_compact(), rand_span());
    write_reg(REG_MIN_BITS, 32'h2000_ffff);
    write_reg(REG_MAX_BITS, 32'h0400_0001);
    for (int i = 0; i < 15; i++) send_item(rand_compact(), rand_span());
    write_reg(REG_MIN_BITS, 32'hffff_ffff);
    write_reg(REG_MAX_BITS, 32'hffff_ffff);
    for (int i = 0; i < 5; i++) send_item(rand_compact(), rand_span());
    write_reg(REG_MIN_BITS, 32'h0);
    write_reg(REG_MAX_BITS, 32'h0);
    for (int i = 0; i < 5; i++) send_item(rand_compact(), rand_span());
    write_reg(REG_MAX_BITS, 32'hffff_ffff);
  endtask

  task automatic test_random();
    for (int p = 0; p < 9; p++) begin
      if (p > 0) begin
        write_reg(REG_TARGET_TIMESPAN, ($urandom_range(0, 2) == 0) ? $urandom
                                        : $urandom_range(1, 5000000));
        write_reg(REG_MIN_BITS, ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom);
        write_reg(REG_MAX_BITS, ($urandom_range(0, 1) == 0) ? 32'hffff_ffff : $urandom);
      end
      for (int i = 0; i < 50; i++) send_item(rand_compact(), rand_span());
    end
  endtask

  initial begin
    int stall;
    out_pop = 1'b0;
    wait (rst_n);
    forever begin
      stall = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      if (expected_compact.size() == 0) begin
        $error("new_compact: unexpected item, actual %h", out_new_compact);
        errors++;
      end else begin
        if (out_new_compact !== expected_compact[0]) begin
          $error("new_compact: expected %h actual %h", expected_compact[0], out_new_compact);
          errors++;
        end
        void'(expected_compact.pop_front());
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_old_compact = '0;
    in_actual_timespan = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_TARGET_TIMESPAN;
    cfg_data = '0;
    period_reg = TT_RESET;
    floor_reg = MIN_RESET;
    ceil_reg = MAX_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_period_extremes();
    test_bounds();
    test_random();
    in_push <= 1'b0;
    wait (expected_compact.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("difficulty_retarget: match");
    end else begin
      $display("difficulty_retarget: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
